### src/bra_pkg.sv
package bra_pkg;

    // Request kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_READ  = 2'd0;
    localparam t_kind KIND_SET   = 2'd1;
    localparam t_kind KIND_CLEAR = 2'd2;
    localparam t_kind KIND_FIND  = 2'd3;

    // Bit index into the map, byte index, run counter
    typedef logic [7:0] t_bitpos;
    typedef logic [4:0] t_byte_idx;
    typedef logic [7:0] t_byte;
    typedef logic [8:0] t_run_cnt;

    // Register map
    localparam int          APB_AW          = 2;
    localparam logic [1:0]  REG_BYTES_IN_USE = 2'd0;
    localparam logic [5:0]  BYTES_IN_USE_RST = 6'd32;

    // Map port command
    typedef struct packed {
        logic      rd_en;
        t_byte_idx rd_addr;
        logic      wr_en;
        t_byte_idx wr_addr;
        t_byte     wr_data;
    } t_map_cmd;

    // Run scanner control and result
    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

    typedef struct packed {
        logic    hit;
        t_bitpos start;
    } t_scan_res;

endpackage

### src/bra_if.sv
// Request channel
interface bra_req_if;
    logic             valid;
    logic             ready;
    bra_pkg::t_kind   kind;
    bra_pkg::t_bitpos position;
    bra_pkg::t_bitpos run_length;

    modport source (output valid, output kind, output position, output run_length,
                    input ready);
    modport sink   (input valid, input kind, input position, input run_length,
                    output ready);
endinterface

// Result channel
interface bra_rsp_if;
    logic             valid;
    logic             ready;
    logic             bit_value;
    logic             found;
    bra_pkg::t_bitpos start_position;

    modport source (output valid, output bit_value, output found, output start_position,
                    input ready);
    modport sink   (input valid, input bit_value, input found, input start_position,
                    output ready);
endinterface

### src/bra_map.sv
module bra_map #(
    parameter int MAP_BYTES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bra_pkg::t_map_cmd i_cmd,
    output bra_pkg::t_byte    o_rd_data
);
    import bra_pkg::*;

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    t_byte                r_mem [MAP_BYTES];
    logic [MAP_BYTES-1:0] r_valid;
    t_byte                r_rd_data;

    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;

    assign w_rd_addr = i_cmd.rd_addr[AW-1:0];
    assign w_wr_addr = i_cmd.wr_addr[AW-1:0];

    // Map storage, no reset; unwritten bytes read as zero via valid bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr] <= i_cmd.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr_en) begin
            r_valid[w_wr_addr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_valid[w_rd_addr] ? r_mem[w_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/bra_scan.sv
module bra_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bra_pkg::t_scan_ctl  i_ctl,
    input  bra_pkg::t_byte      i_byte,
    input  bra_pkg::t_byte_idx  i_byte_idx,
    input  bra_pkg::t_bitpos    i_len,
    output bra_pkg::t_scan_res  o_res
);
    import bra_pkg::*;

    t_run_cnt r_count;
    t_run_cnt n_count;
    logic     w_hit;
    logic [2:0] w_hit_bit;

    // Walk the eight bits of this byte, LSB first
    always_comb begin
        n_count   = r_count;
        w_hit     = 1'b0;
        w_hit_bit = '0;
        for (int j = 0; j < 8; j++) begin
            if (i_byte[j]) begin
                n_count = n_count + 9'd1;
            end else begin
                n_count = '0;
            end
            if (!w_hit && (n_count == {1'b0, i_len})) begin
                w_hit     = 1'b1;
                w_hit_bit = 3'(j);
            end
        end
    end

    // Run length carried across bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_count <= '0;
        end else if (i_ctl.step) begin
            r_count <= n_count;
        end
    end

    // start = bit index + 1 - length, modulo 256
    assign o_res.hit   = w_hit;
    assign o_res.start = {i_byte_idx, w_hit_bit} + 8'd1 - i_len;

endmodule

### src/bitmap_run_allocator.sv
// Bitmap run allocator: a map of MAP_BYTES*8 bits where 1 marks a free slot, cleared at
// reset (no clearing pass; per-byte valid bits make it read as zero at once). Requests
// read, set or clear one bit, or find the first run of run_length ones, scanning from bit 0
// over min(bytes_in_use, MAP_BYTES) bytes. Read, set and clear pass from accept through an op
// state to a done state; a find goes to done directly if run_length or bytes_in_use is zero, else
// scans to a hit or the last used byte; the map memory delivers one byte per cycle through its
// registered read port and the scanner consumes one byte per cycle. One request is in work
// at a time; a finished word waits in the output register while the next is accepted.
// bytes_in_use sits at APB address 0 and may be written only while the block is idle.
module bitmap_run_allocator #(
    parameter int MAP_BYTES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bra_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    bra_req_if.sink                    i_req,
    bra_rsp_if.source                  o_rsp
);
    import bra_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_OP   = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    t_kind      r_kind;
    t_bitpos    r_pos;
    t_bitpos    r_len;
    t_byte_idx  r_idx, n_idx;
    t_byte_idx  r_last, n_last;
    logic [5:0] r_biu;

    logic       r_res_bit, n_res_bit;
    logic       r_res_found, n_res_found;
    t_bitpos    r_res_start, n_res_start;

    logic       r_out_valid;
    logic       r_out_bit;
    logic       r_out_found;
    t_bitpos    r_out_start;

    logic       w_acc;
    logic       w_load_out;
    logic [5:0] w_nbytes;
    logic       w_in_range;
    t_byte      w_mask;
    t_byte      w_rd_data;
    t_map_cmd   w_cmd;
    t_scan_ctl  w_scan_ctl;
    t_scan_res  w_scan_res;

    // APB config port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_BYTES_IN_USE) ? {26'd0, r_biu} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu <= BYTES_IN_USE_RST;
        end else if (psel && penable && pwrite && pready && (paddr == REG_BYTES_IN_USE)) begin
            r_biu <= pwdata[5:0];
        end
    end

    // Handshake
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_load_out  = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);

    assign w_nbytes   = (r_biu > 6'(MAP_BYTES)) ? 6'(MAP_BYTES) : r_biu;
    assign w_in_range = ({1'b0, r_pos[7:3]} < 6'(MAP_BYTES));
    assign w_mask     = 8'd1 << r_pos[2:0];

    bra_map #(
        .MAP_BYTES (MAP_BYTES)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_rd_data (w_rd_data)
    );

    bra_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_scan_ctl),
        .i_byte     (w_rd_data),
        .i_byte_idx (r_idx),
        .i_len      (r_len),
        .o_res      (w_scan_res)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_last      = r_last;
        n_res_bit   = r_res_bit;
        n_res_found = r_res_found;
        n_res_start = r_res_start;
        w_cmd       = '0;
        w_scan_ctl  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_res_bit   = 1'b0;
                    n_res_found = 1'b0;
                    n_res_start = '0;
                    if (i_req.kind != KIND_FIND) begin
                        w_cmd.rd_en   = 1'b1;
                        w_cmd.rd_addr = i_req.position[7:3];
                        n_state       = ST_OP;
                    end else if ((i_req.run_length == '0) || (w_nbytes == '0)) begin
                        n_state = ST_DONE;
                    end else begin
                        w_cmd.rd_en      = 1'b1;
                        w_cmd.rd_addr    = '0;
                        w_scan_ctl.clear = 1'b1;
                        n_idx            = '0;
                        n_last           = 5'(w_nbytes - 6'd1);
                        n_state          = ST_SCAN;
                    end
                end
            end
            ST_OP: begin
                unique case (r_kind)
                    KIND_READ: begin
                        n_res_bit = w_in_range & w_rd_data[r_pos[2:0]];
                    end
                    KIND_SET: begin
                        w_cmd.wr_en   = w_in_range;
                        w_cmd.wr_addr = r_pos[7:3];
                        w_cmd.wr_data = w_rd_data | w_mask;
                    end
                    KIND_CLEAR: begin
                        w_cmd.wr_en   = w_in_range;
                        w_cmd.wr_addr = r_pos[7:3];
                        w_cmd.wr_data = w_rd_data & ~w_mask;
                    end
                    default: begin
                    end
                endcase
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                w_scan_ctl.step = 1'b1;
                if (w_scan_res.hit) begin
                    n_res_found = 1'b1;
                    n_res_start = w_scan_res.start;
                    n_state     = ST_DONE;
                end else if (r_idx == r_last) begin
                    n_state = ST_DONE;
                end else begin
                    w_cmd.rd_en   = 1'b1;
                    w_cmd.rd_addr = r_idx + 5'd1;
                    n_idx         = r_idx + 5'd1;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request and working registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_kind <= i_req.kind;
            r_pos  <= i_req.position;
            r_len  <= i_req.run_length;
        end
        r_idx       <= n_idx;
        r_last      <= n_last;
        r_res_bit   <= n_res_bit;
        r_res_found <= n_res_found;
        r_res_start <= n_res_start;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_bit   <= r_res_bit;
            r_out_found <= r_res_found;
            r_out_start <= r_res_start;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.bit_value      = r_out_bit;
    assign o_rsp.found          = r_out_found;
    assign o_rsp.start_position = r_out_start;

`ifndef SYNTHESIS
    // A result word never claims both a bit read and a found run
    a_res_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.bit_value && o_rsp.found))
        else $error("result carries both bit_value and found");

    // Start position is zero unless a run was found
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.start_position == '0))
        else $error("start_position nonzero without found");

    // Scan never walks past the last byte in use
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= r_last))
        else $error("scan index beyond last byte");

    // An accepted request always starts work
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state != ST_IDLE))
        else $error("accepted request left block idle");

    // A finished result waits while the output word is stalled
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && r_out_valid && !o_rsp.ready) |=> (r_state == ST_DONE))
        else $error("result dropped while output stalled");
`endif

endmodule
